[rtl/btr_pkg.sv]
// Shared types and codes for the buffer token registry.
`default_nettype none

package btr_pkg;

   typedef enum logic [2:0] {
      OP_INIT       = 3'd0,
      OP_ACQUIRE    = 3'd1,
      OP_FIND       = 3'd2,
      OP_RELEASE    = 3'd3,
      OP_HOLD       = 3'd4,
      OP_REACTIVATE = 3'd5
   } btr_op_type;

   typedef enum logic [1:0] {
      ES_AVAILABLE = 2'd0,
      ES_OCCUPIED  = 2'd1,
      ES_ON_HOLD   = 2'd2
   } btr_entry_type;

   typedef enum logic [1:0] {
      RS_OK           = 2'd0,
      RS_INVALID      = 2'd1,
      RS_NOT_OCCUPIED = 2'd2
   } btr_status_type;

   typedef struct packed {
      logic accept;
      logic cnt_clr;
      logic sweep_we;
      logic clearing;
      logic commit;
      logic load_rsp;
   } btr_cmd_type;

   typedef struct packed {
      logic init_last;
      logic clear_last;
   } btr_sts_type;

endpackage

`default_nettype wire

[rtl/buffer_token_registry.sv]
// Top level of the buffer token registry.
//
// Requests arrive on the req_ channel as one transfer each: a command, a pool,
// a token and the size and addresses that acquire stores. Every request gives
// exactly one transfer on the rsp_ channel with a status and, for a successful
// find, the stored size and addresses.
// Each pool has ENTRIES records held in single-port memories with registered
// reads. A command is read in the cycle of its transfer and decided and
// written back in its execute step, and the block takes no new request until
// that read-modify-write of one record is done. Init walks its pool one
// record per cycle in its sweep step, then goes to the execute step.
// After reset the block clears both pools, one record per cycle, with
// req_ready low; then every record is available.
// The result sits in an output register. The next request is taken while it
// waits; if the receiver still stalls when that request is decided, the block
// holds in its execute step until the register is free.
`default_nettype none

module buffer_token_registry #(
   parameter int ENTRIES = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_command,
   input  wire logic        req_pool,
   input  wire logic [15:0] req_token_id,
   input  wire logic [15:0] req_buffer_size,
   input  wire logic [63:0] req_phys_addr,
   input  wire logic [63:0] req_virt_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_found_size,
   output logic [63:0]      rsp_found_phys,
   output logic [63:0]      rsp_found_virt
);

   btr_pkg::btr_cmd_type cmd;
   btr_pkg::btr_sts_type sts;

   btr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   btr_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_pool        (req_pool),
      .req_token_id    (req_token_id),
      .req_buffer_size (req_buffer_size),
      .req_phys_addr   (req_phys_addr),
      .req_virt_addr   (req_virt_addr),
      .rsp_status      (rsp_status),
      .rsp_found_size  (rsp_found_size),
      .rsp_found_phys  (rsp_found_phys),
      .rsp_found_virt  (rsp_found_virt)
   );

endmodule

`default_nettype wire

[rtl/btr_ctrl.sv]
// Controller state machine of the buffer token registry.
`default_nettype none

module btr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output btr_pkg::btr_cmd_type    cmd,
   input  wire btr_pkg::btr_sts_type sts
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SWEEP,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      cmd.accept   = accept;
      cmd.cnt_clr  = accept;
      cmd.sweep_we = (state_ff == S_CLEAR) || (state_ff == S_SWEEP);
      cmd.clearing = (state_ff == S_CLEAR);
      cmd.commit   = (state_ff == S_EXEC) && out_free;
      cmd.load_rsp = (state_ff == S_EXEC) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (sts.clear_last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  if (req_command == btr_pkg::OP_INIT) state_ff <= S_SWEEP;
                  else state_ff <= S_EXEC;
               end
            end
            S_SWEEP: begin
               if (sts.init_last) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   a_no_accept_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while the previous one is still at work");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("response raised outside the execute step");

   a_sweep_no_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sweep_we && cmd.commit))
      else $error("sweep write collides with a command write");

endmodule

`default_nettype wire

[rtl/btr_dpath.sv]
// Datapath of the buffer token registry: record memories, decode and result register.
`default_nettype none

module btr_dpath #(
   parameter int ENTRIES = 8192
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire btr_pkg::btr_cmd_type cmd,
   output btr_pkg::btr_sts_type    sts,
   input  wire logic [2:0]         req_command,
   input  wire logic               req_pool,
   input  wire logic [15:0]        req_token_id,
   input  wire logic [15:0]        req_buffer_size,
   input  wire logic [63:0]        req_phys_addr,
   input  wire logic [63:0]        req_virt_addr,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_found_size,
   output logic [63:0]             rsp_found_phys,
   output logic [63:0]             rsp_found_virt
);

   localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int DEPTH = 2 ** (AW + 1);

   logic [1:0]  state_mem [DEPTH];
   logic [15:0] size_mem  [DEPTH];
   logic [63:0] phys_mem  [DEPTH];
   logic [63:0] virt_mem  [DEPTH];

   logic [2:0]  command_ff;
   logic [15:0] token_ff;
   logic        pool_ff;
   logic [AW:0] addr_ff;
   logic [15:0] size_ff;
   logic [63:0] phys_ff;
   logic [63:0] virt_ff;

   logic [1:0]  rd_state_ff;
   logic [15:0] rd_size_ff;
   logic [63:0] rd_phys_ff;
   logic [63:0] rd_virt_ff;

   logic [AW:0] cnt_ff;
   logic [AW:0] sweep_addr;
   logic [AW:0] rd_addr;

   logic        tok_ok;
   logic [1:0]  status;
   logic        found;
   logic        st_we;
   logic [1:0]  st_next;
   logic        data_we;

   logic [1:0]  status_ff;
   logic [15:0] found_size_ff;
   logic [63:0] found_phys_ff;
   logic [63:0] found_virt_ff;

   assign rd_addr    = {req_pool, req_token_id[AW-1:0]};
   assign sweep_addr = cmd.clearing ? cnt_ff : {pool_ff, cnt_ff[AW-1:0]};

   assign sts.clear_last = (cnt_ff == {(AW + 1){1'b1}});
   assign sts.init_last  = (cnt_ff[AW-1:0] == AW'(ENTRIES - 1));

   assign tok_ok = ({1'b0, token_ff} < 17'(ENTRIES));

   always_comb begin
      status  = btr_pkg::RS_INVALID;
      found   = 1'b0;
      st_we   = 1'b0;
      st_next = btr_pkg::ES_AVAILABLE;
      data_we = 1'b0;
      case (command_ff)
         btr_pkg::OP_INIT: begin
            status = btr_pkg::RS_OK;
         end
         btr_pkg::OP_ACQUIRE: begin
            if (tok_ok && rd_state_ff == btr_pkg::ES_AVAILABLE) begin
               status  = btr_pkg::RS_OK;
               st_we   = 1'b1;
               st_next = btr_pkg::ES_OCCUPIED;
               data_we = 1'b1;
            end
         end
         btr_pkg::OP_FIND: begin
            if (tok_ok) begin
               if (rd_state_ff == btr_pkg::ES_OCCUPIED) begin
                  status = btr_pkg::RS_OK;
                  found  = 1'b1;
               end else begin
                  status = btr_pkg::RS_NOT_OCCUPIED;
               end
            end
         end
         btr_pkg::OP_RELEASE: begin
            if (tok_ok) begin
               status  = btr_pkg::RS_OK;
               st_we   = 1'b1;
               st_next = btr_pkg::ES_AVAILABLE;
            end
         end
         btr_pkg::OP_HOLD: begin
            if (tok_ok && rd_state_ff == btr_pkg::ES_OCCUPIED) begin
               status  = btr_pkg::RS_OK;
               st_we   = 1'b1;
               st_next = btr_pkg::ES_ON_HOLD;
            end
         end
         btr_pkg::OP_REACTIVATE: begin
            if (tok_ok && rd_state_ff == btr_pkg::ES_ON_HOLD) begin
               status  = btr_pkg::RS_OK;
               st_we   = 1'b1;
               st_next = btr_pkg::ES_OCCUPIED;
            end
         end
         default: status = btr_pkg::RS_INVALID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else if (cmd.cnt_clr) cnt_ff <= '0;
      else if (cmd.sweep_we) cnt_ff <= cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         command_ff <= req_command;
         token_ff   <= req_token_id;
         pool_ff    <= req_pool;
         addr_ff    <= rd_addr;
         size_ff    <= req_buffer_size;
         phys_ff    <= req_phys_addr;
         virt_ff    <= req_virt_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_we) state_mem[sweep_addr] <= btr_pkg::ES_AVAILABLE;
      else if (cmd.commit && st_we) state_mem[addr_ff] <= st_next;
      if (cmd.accept) rd_state_ff <= state_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && data_we) begin
         size_mem[addr_ff] <= size_ff;
         phys_mem[addr_ff] <= phys_ff;
         virt_mem[addr_ff] <= virt_ff;
      end
      if (cmd.accept) begin
         rd_size_ff <= size_mem[rd_addr];
         rd_phys_ff <= phys_mem[rd_addr];
         rd_virt_ff <= virt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff     <= status;
         found_size_ff <= found ? rd_size_ff : 16'd0;
         found_phys_ff <= found ? rd_phys_ff : 64'd0;
         found_virt_ff <= found ? rd_virt_ff : 64'd0;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_found_size = found_size_ff;
   assign rsp_found_phys = found_phys_ff;
   assign rsp_found_virt = found_virt_ff;

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the buffer token registry.
`timescale 1ns / 1ps

module tb;

   localparam int ENTRIES = 8192;
   localparam int RANDOM_ITEMS = 1000;
   localparam int QUIET_FIRST = 300;
   localparam int QUIET_LAST = 449;
   localparam int HOLD_ITEM = 600;
   localparam int DRAIN_ITEM = 800;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   localparam logic [63:0] NIL64 = 64'd0;
   localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] PAT_A = 64'h5555_5555_5555_5555;
   localparam logic [63:0] PAT_B = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam bit GIVEN = 1'b1;
   localparam bit PREDICT = 1'b0;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] size;
      logic [63:0] phys;
      logic [63:0] virt;
   } registry_result_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        pool;
      logic [15:0] tok;
      logic [15:0] size;
      logic [63:0] phys;
      logic [63:0] virt;
      bit          given;
      logic [1:0]  status;
      logic [15:0] fsize;
      logic [63:0] fphys;
      logic [63:0] fvirt;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = 3'd0;
   logic        req_pool = 1'b0;
   logic [15:0] req_token_id = 16'd0;
   logic [15:0] req_buffer_size = 16'd0;
   logic [63:0] req_phys_addr = 64'd0;
   logic [63:0] req_virt_addr = 64'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_found_size;
   logic [63:0] rsp_found_phys;
   logic [63:0] rsp_found_virt;

   btr_pkg::btr_entry_type rec_state [2*ENTRIES];
   logic [15:0]            rec_size [2*ENTRIES];
   logic [63:0]            rec_phys [2*ENTRIES];
   logic [63:0]            rec_virt [2*ENTRIES];

   registry_result_type pending_results [$];
   directed_row_type    directed_rows [26];
   int                  mismatch_count = 0;
   bit                  quiet = 1'b0;
   bit                  hold_rsp = 1'b0;
   int                  hold_left = 0;
   registry_result_type head;

   buffer_token_registry #(.ENTRIES(ENTRIES)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pool        (req_pool),
      .req_token_id    (req_token_id),
      .req_buffer_size (req_buffer_size),
      .req_phys_addr   (req_phys_addr),
      .req_virt_addr   (req_virt_addr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_size  (rsp_found_size),
      .rsp_found_phys  (rsp_found_phys),
      .rsp_found_virt  (rsp_found_virt)
   );

   always #2 clock = ~clock;

   function automatic void clear_pool(input logic pool);
      int base;
      base = int'(pool) * ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
         rec_state[base + i] = btr_pkg::ES_AVAILABLE;
         rec_size[base + i] = 16'd0;
         rec_phys[base + i] = 64'd0;
         rec_virt[base + i] = 64'd0;
      end
   endfunction

   function automatic registry_result_type registry_apply(input logic [2:0] cmd,
         input logic pool, input logic [15:0] tok, input logic [15:0] size,
         input logic [63:0] phys, input logic [63:0] virt);
      registry_result_type res;
      int slot;
      res = '0;
      res.status = btr_pkg::RS_INVALID;
      slot = int'(pool) * ENTRIES + int'(tok);
      if (cmd == btr_pkg::OP_INIT) begin
         clear_pool(pool);
         res.status = btr_pkg::RS_OK;
      end else if (int'(tok) < ENTRIES) begin
         case (cmd)
            btr_pkg::OP_ACQUIRE: begin
               if (rec_state[slot] == btr_pkg::ES_AVAILABLE) begin
                  rec_size[slot] = size;
                  rec_phys[slot] = phys;
                  rec_virt[slot] = virt;
                  rec_state[slot] = btr_pkg::ES_OCCUPIED;
                  res.status = btr_pkg::RS_OK;
               end
            end
            btr_pkg::OP_FIND: begin
               if (rec_state[slot] == btr_pkg::ES_OCCUPIED) begin
                  res.size = rec_size[slot];
                  res.phys = rec_phys[slot];
                  res.virt = rec_virt[slot];
                  res.status = btr_pkg::RS_OK;
               end else begin
                  res.status = btr_pkg::RS_NOT_OCCUPIED;
               end
            end
            btr_pkg::OP_RELEASE: begin
               rec_state[slot] = btr_pkg::ES_AVAILABLE;
               res.status = btr_pkg::RS_OK;
            end
            btr_pkg::OP_HOLD: begin
               if (rec_state[slot] == btr_pkg::ES_OCCUPIED) begin
                  rec_state[slot] = btr_pkg::ES_ON_HOLD;
                  res.status = btr_pkg::RS_OK;
               end
            end
            btr_pkg::OP_REACTIVATE: begin
               if (rec_state[slot] == btr_pkg::ES_ON_HOLD) begin
                  rec_state[slot] = btr_pkg::ES_OCCUPIED;
                  res.status = btr_pkg::RS_OK;
               end
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   function automatic logic [2:0] pick_command();
      int unsigned r;
      r = $urandom_range(999);
      if (r < 15) return btr_pkg::OP_INIT;
      if (r < 35) return ($urandom_range(1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
      if (r < 300) return btr_pkg::OP_ACQUIRE;
      if (r < 560) return btr_pkg::OP_FIND;
      if (r < 680) return btr_pkg::OP_RELEASE;
      if (r < 840) return btr_pkg::OP_HOLD;
      return btr_pkg::OP_REACTIVATE;
   endfunction

   function automatic logic [15:0] pick_token();
      int unsigned r;
      int unsigned k;
      r = $urandom_range(99);
      k = $urandom_range(15);
      if (r < 80) return (k < 8) ? 16'(k) : 16'(ENTRIES - 16 + k);
      if (r < 88) return 16'($urandom_range(ENTRIES - 1));
      if (r < 94) return 16'($urandom_range(65535, ENTRIES));
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic [63:0] pick_addr();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return NIL64;
      if (r < 10) return ONES64;
      return {$urandom, $urandom};
   endfunction

   // Offers one request and returns at the edge where its transfer takes place.
   task automatic offer(input logic [2:0] cmd, input logic pool, input logic [15:0] tok,
         input logic [15:0] size, input logic [63:0] phys, input logic [63:0] virt);
      if (!quiet && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_pool <= pool;
      req_token_id <= tok;
      req_buffer_size <= size;
      req_phys_addr <= phys;
      req_virt_addr <= virt;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   initial begin : stimulus
      directed_row_type    row;
      registry_result_type predicted;
      logic [2:0]          cmd;
      logic                pool;
      logic [15:0]         tok;
      logic [15:0]         size;
      logic [63:0]         phys;
      logic [63:0]         virt;

      directed_rows = '{
         '{btr_pkg::OP_FIND, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_NOT_OCCUPIED, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_ACQUIRE, 1'b0, 16'd0, 16'hFFFF, ONES64, ONES64,
           GIVEN, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_FIND, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_OK, 16'hFFFF, ONES64, ONES64},
         '{btr_pkg::OP_ACQUIRE, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_HOLD, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_FIND, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_NOT_OCCUPIED, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_HOLD, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_REACTIVATE, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_REACTIVATE, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_ACQUIRE, 1'b1, 16'd8191, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_FIND, 1'b1, 16'd8191, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_FIND, 1'b0, 16'd8191, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_NOT_OCCUPIED, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_ACQUIRE, 1'b0, 16'd8192, 16'h1234, PAT_A, PAT_B,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_FIND, 1'b1, 16'hFFFF, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_RELEASE, 1'b0, 16'hFFFF, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_HOLD, 1'b1, 16'd8192, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_REACTIVATE, 1'b0, 16'hFFFF, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_RELEASE, 1'b1, 16'd5, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_HOLD, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           PREDICT, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_RELEASE, 1'b0, 16'd0, 16'd0, NIL64, NIL64,
           PREDICT, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{OP_RSVD_6, 1'b0, 16'd1, 16'hFFFF, ONES64, ONES64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{OP_RSVD_7, 1'b1, 16'd8191, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_INVALID, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_INIT, 1'b1, 16'hFFFF, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_FIND, 1'b1, 16'd8191, 16'd0, NIL64, NIL64,
           GIVEN, btr_pkg::RS_NOT_OCCUPIED, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_ACQUIRE, 1'b0, 16'd1, 16'hA5A5, PAT_A, PAT_B,
           PREDICT, btr_pkg::RS_OK, 16'd0, NIL64, NIL64},
         '{btr_pkg::OP_FIND, 1'b0, 16'd1, 16'd0, NIL64, NIL64,
           PREDICT, btr_pkg::RS_OK, 16'd0, NIL64, NIL64}
      };

      clear_pool(1'b0);
      clear_pool(1'b1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer(row.cmd, row.pool, row.tok, row.size, row.phys, row.virt);
         predicted = registry_apply(row.cmd, row.pool, row.tok, row.size, row.phys,
                                    row.virt);
         if (row.given) begin
            predicted.status = row.status;
            predicted.size = row.fsize;
            predicted.phys = row.fphys;
            predicted.virt = row.fvirt;
         end
         pending_results.push_back(predicted);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
         if (n == HOLD_ITEM) hold_rsp = 1'b1;
         if (n == DRAIN_ITEM) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
         cmd = pick_command();
         pool = 1'($urandom_range(1));
         tok = pick_token();
         size = 16'($urandom_range(65535));
         phys = pick_addr();
         virt = pick_addr();
         offer(cmd, pool, tok, size, phys, virt);
         pending_results.push_back(registry_apply(cmd, pool, tok, size, phys, virt));
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with no request outstanding");
            mismatch_count++;
         end else begin
            head = pending_results.pop_front();
            if (rsp_status !== head.status) begin
               $error("status: expected %0d, got %0d", head.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_found_size !== head.size) begin
               $error("found_size: expected %h, got %h", head.size, rsp_found_size);
               mismatch_count++;
            end
            if (rsp_found_phys !== head.phys) begin
               $error("found_phys: expected %h, got %h", head.phys, rsp_found_phys);
               mismatch_count++;
            end
            if (rsp_found_virt !== head.virt) begin
               $error("found_virt: expected %h, got %h", head.virt, rsp_found_virt);
               mismatch_count++;
            end
         end
      end
      if (hold_rsp && hold_left == 0) begin
         hold_rsp = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 31);
      end
   end

   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
